/* rtl/nptr_pkg.sv */
// Package for the next-permutation trace block: sizes, record kinds,
// and the command/status structs between controller and datapath.
// No dependencies.
package nptr_pkg;

  localparam int MAX_LEN    = 16;
  localparam int ELEM_WIDTH = 16;

  // Fixed widths of the word fields
  localparam int VAL_W   = 16;
  localparam int KIND_W  = 3;
  localparam int FIDX_W  = 4;
  localparam int EVT_W   = 6;

  // Internal widths that follow from the array depth
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  typedef logic signed [ELEM_WIDTH-1:0] elem_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASCENT    = 3'd0,
    KIND_SUCCESSOR = 3'd1,
    KIND_PIVOT     = 3'd2,
    KIND_REVERSE   = 3'd3,
    KIND_ELEMENT   = 3'd4,
    KIND_DONE      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    WR_IN = 2'd0,
    WR_A  = 2'd1,
    WR_B  = 2'd2
  } wsel_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    wsel_t             wr_sel;
    logic              emit;
    kind_t             kind;
    logic [FIDX_W-1:0] first_idx;
    logic [FIDX_W-1:0] second_idx;
    logic              val_sel;
    logic [EVT_W-1:0]  total;
    logic              wrapped;
    logic              final_rec;
  } cmd_t;

  typedef struct packed {
    logic a_lt_b;
    logic out_free;
  } sts_t;

endpackage

/* rtl/nptr_if.sv */
// Valid/ready channel interfaces for the element input and record output.
// Depends on nptr_pkg for field widths.
interface nptr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [nptr_pkg::VAL_W-1:0]      element_value;
  logic                                   end_of_array;

  modport source (output valid, output element_value, output end_of_array, input ready);
  modport sink   (input valid, input element_value, input end_of_array, output ready);
endinterface

interface nptr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [nptr_pkg::KIND_W-1:0]            record_kind;
  logic [nptr_pkg::FIDX_W-1:0]            first_index;
  logic [nptr_pkg::FIDX_W-1:0]            second_index;
  logic signed [nptr_pkg::VAL_W-1:0]      permuted_value;
  logic [nptr_pkg::EVT_W-1:0]             event_total;
  logic                                   wrapped;
  logic                                   final_record;

  modport source (output valid, output record_kind, output first_index, output second_index,
                  output permuted_value, output event_total, output wrapped,
                  output final_record, input ready);
  modport sink   (input valid, input record_kind, input first_index, input second_index,
                  input permuted_value, input event_total, input wrapped,
                  input final_record, output ready);
endinterface

/* rtl/next_permutation_trace.sv */
// Next-permutation trace block, top level: joins controller and datapath
// to the input and record channels. Uses nptr_pkg, nptr_if, nptr_ctrl,
// nptr_datapath.
//
// Elements load at one word per cycle into a 16-entry store; the word
// flagged end_of_array starts the walk, during which no input is taken.
// The walk runs on one store with a single write port and a registered
// read: each ascent or successor compare is a read then a record, the
// pivot is a record then two writes, each reversal swap is a check, a
// read, a record and two writes, with one final check, each element
// record is a read then a record, and the done record is a record
// alone; every record waits out any output stall. Arrays of fewer than
// two elements go straight from loading to the done record. A done record
// still waiting at the output does not block loading the next array.
module next_permutation_trace (
  input  logic        clk,
  input  logic        rst_n,
  nptr_in_if.sink     in_chan,
  nptr_out_if.source  out_chan
);

  nptr_pkg::cmd_t cmd;
  nptr_pkg::sts_t sts;

  nptr_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_chan.valid),
    .in_end_of_array (in_chan.end_of_array),
    .in_ready        (in_chan.ready),
    .cmd             (cmd),
    .sts             (sts)
  );

  nptr_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_element_value   (in_chan.element_value),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_record_kind    (out_chan.record_kind),
    .out_first_index    (out_chan.first_index),
    .out_second_index   (out_chan.second_index),
    .out_permuted_value (out_chan.permuted_value),
    .out_event_total    (out_chan.event_total),
    .out_wrapped        (out_chan.wrapped),
    .out_final_record   (out_chan.final_record)
  );

endmodule

/* rtl/nptr_datapath.sv */
// Datapath: element memory with two registered read ports and one write
// port, signed compare, and the output word register. Uses nptr_pkg.
module nptr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nptr_pkg::cmd_t                    cmd,
  output nptr_pkg::sts_t                    sts,
  input  logic signed [nptr_pkg::VAL_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [nptr_pkg::KIND_W-1:0]       out_record_kind,
  output logic [nptr_pkg::FIDX_W-1:0]      out_first_index,
  output logic [nptr_pkg::FIDX_W-1:0]      out_second_index,
  output logic signed [nptr_pkg::VAL_W-1:0] out_permuted_value,
  output logic [nptr_pkg::EVT_W-1:0]        out_event_total,
  output logic                              out_wrapped,
  output logic                              out_final_record
);

  nptr_pkg::elem_t mem [nptr_pkg::MAX_LEN];
  nptr_pkg::elem_t rd_a_r, rd_b_r;
  nptr_pkg::elem_t wr_data;

  logic                              out_valid_r;
  logic [nptr_pkg::KIND_W-1:0]       kind_r;
  logic [nptr_pkg::FIDX_W-1:0]      first_r, second_r;
  logic signed [nptr_pkg::VAL_W-1:0] value_r;
  logic [nptr_pkg::EVT_W-1:0]        total_r;
  logic                              wrapped_r, final_r;
  logic                              load_out;

  always_comb begin
    unique case (cmd.wr_sel)
      nptr_pkg::WR_A: wr_data = rd_a_r;
      nptr_pkg::WR_B: wr_data = rd_b_r;
      default:        wr_data = nptr_pkg::elem_t'(in_element_value);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
  end

  // Hold read data outside read cycles so swaps see the pre-swap pair
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_a_r <= mem[cmd.rd_addr_a];
      rd_b_r <= mem[cmd.rd_addr_b];
    end
  end

  assign sts.a_lt_b   = rd_a_r < rd_b_r;
  assign sts.out_free = !out_valid_r || out_ready;
  assign load_out     = cmd.emit && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind_r    <= cmd.kind;
      first_r   <= cmd.first_idx;
      second_r  <= cmd.second_idx;
      value_r   <= cmd.val_sel ? nptr_pkg::VAL_W'(rd_a_r) : '0;
      total_r   <= cmd.total;
      wrapped_r <= cmd.wrapped;
      final_r   <= cmd.final_rec;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_kind    = kind_r;
  assign out_first_index    = first_r;
  assign out_second_index   = second_r;
  assign out_permuted_value = value_r;
  assign out_event_total    = total_r;
  assign out_wrapped        = wrapped_r;
  assign out_final_record   = final_r;

endmodule

/* rtl/nptr_ctrl.sv */
// Controller: loads the array, then sequences ascent search, successor
// search, pivot swap, suffix reversal, element dump and done. Uses nptr_pkg.
module nptr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_end_of_array,
  output logic           in_ready,
  output nptr_pkg::cmd_t cmd,
  input  nptr_pkg::sts_t sts
);

  typedef enum logic [15:0] {
    ST_LOAD     = 16'h0001,
    ST_ASC_RD   = 16'h0002,
    ST_ASC_CMP  = 16'h0004,
    ST_SUC_RD   = 16'h0008,
    ST_SUC_CMP  = 16'h0010,
    ST_PIV      = 16'h0020,
    ST_SWA      = 16'h0040,
    ST_SWB      = 16'h0080,
    ST_REV      = 16'h0100,
    ST_REV_RD   = 16'h0200,
    ST_REV_EMIT = 16'h0400,
    ST_REV_WA   = 16'h0800,
    ST_REV_WB   = 16'h1000,
    ST_ELEM_RD  = 16'h2000,
    ST_ELEM_EMIT= 16'h4000,
    ST_DONE     = 16'h8000
  } state_t;

  localparam int CW = nptr_pkg::CNT_W;
  localparam int IW = nptr_pkg::IDX_W;
  localparam int FW = nptr_pkg::FIDX_W;
  localparam int EW = nptr_pkg::EVT_W;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic [CW-1:0]  scan_r, scan_nxt;
  logic [IW-1:0]  pivot_r, pivot_nxt;
  logic [IW-1:0]  left_r, left_nxt;
  logic [IW-1:0]  right_r, right_nxt;
  logic [EW-1:0]  evt_r, evt_nxt;
  logic           wrap_r, wrap_nxt;
  logic [IW-1:0]  scan_idx, scan_m1_idx, last_idx;

  assign scan_idx    = scan_r[IW-1:0];
  assign scan_m1_idx = IW'(scan_r - CW'(1));
  assign last_idx    = IW'(n_r - CW'(1));
  assign in_ready    = (state_r == ST_LOAD);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    n_nxt     = n_r;
    scan_nxt  = scan_r;
    pivot_nxt = pivot_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    evt_nxt   = evt_r;
    wrap_nxt  = wrap_r;

    cmd            = '0;
    cmd.wr_sel     = nptr_pkg::WR_IN;
    cmd.kind       = nptr_pkg::KIND_DONE;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          // drop elements beyond the store depth
          if (fill_r < CW'(nptr_pkg::MAX_LEN)) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = fill_r[IW-1:0];
            fill_nxt    = fill_r + CW'(1);
          end
          if (in_end_of_array) begin
            n_nxt    = fill_nxt;
            evt_nxt  = '0;
            wrap_nxt = 1'b0;
            if (fill_nxt < CW'(2)) begin
              state_nxt = ST_DONE;
            end else begin
              scan_nxt  = fill_nxt - CW'(1);
              state_nxt = ST_ASC_RD;
            end
          end
        end
      end
      ST_ASC_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = scan_m1_idx;
        cmd.rd_addr_b = scan_idx;
        state_nxt     = ST_ASC_CMP;
      end
      ST_ASC_CMP: begin
        cmd.emit       = 1'b1;
        cmd.kind       = nptr_pkg::KIND_ASCENT;
        cmd.first_idx  = FW'(scan_m1_idx);
        cmd.second_idx = FW'(scan_idx);
        if (sts.out_free) begin
          evt_nxt = evt_r + EW'(1);
          if (sts.a_lt_b) begin
            pivot_nxt = scan_m1_idx;
            scan_nxt  = n_r - CW'(1);
            state_nxt = ST_SUC_RD;
          end else if (scan_r == CW'(1)) begin
            // no ascent: reverse the whole array
            wrap_nxt  = 1'b1;
            left_nxt  = '0;
            right_nxt = last_idx;
            state_nxt = ST_REV;
          end else begin
            scan_nxt  = scan_r - CW'(1);
            state_nxt = ST_ASC_RD;
          end
        end
      end
      ST_SUC_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = pivot_r;
        cmd.rd_addr_b = scan_idx;
        state_nxt     = ST_SUC_CMP;
      end
      ST_SUC_CMP: begin
        cmd.emit       = 1'b1;
        cmd.kind       = nptr_pkg::KIND_SUCCESSOR;
        cmd.first_idx  = FW'(pivot_r);
        cmd.second_idx = FW'(scan_idx);
        if (sts.out_free) begin
          evt_nxt = evt_r + EW'(1);
          if (sts.a_lt_b || scan_m1_idx == pivot_r) begin
            state_nxt = ST_PIV;
          end else begin
            scan_nxt  = scan_r - CW'(1);
            state_nxt = ST_SUC_RD;
          end
        end
      end
      ST_PIV: begin
        cmd.emit       = 1'b1;
        cmd.kind       = nptr_pkg::KIND_PIVOT;
        cmd.first_idx  = FW'(pivot_r);
        cmd.second_idx = FW'(scan_idx);
        if (sts.out_free) begin
          evt_nxt   = evt_r + EW'(1);
          state_nxt = ST_SWA;
        end
      end
      ST_SWA: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = pivot_r;
        cmd.wr_sel  = nptr_pkg::WR_B;
        state_nxt   = ST_SWB;
      end
      ST_SWB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = scan_idx;
        cmd.wr_sel  = nptr_pkg::WR_A;
        left_nxt    = pivot_r + IW'(1);
        right_nxt   = last_idx;
        state_nxt   = ST_REV;
      end
      ST_REV: begin
        if (left_r < right_r) begin
          state_nxt = ST_REV_RD;
        end else begin
          scan_nxt  = '0;
          state_nxt = ST_ELEM_RD;
        end
      end
      ST_REV_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = left_r;
        cmd.rd_addr_b = right_r;
        state_nxt     = ST_REV_EMIT;
      end
      ST_REV_EMIT: begin
        cmd.emit       = 1'b1;
        cmd.kind       = nptr_pkg::KIND_REVERSE;
        cmd.first_idx  = FW'(left_r);
        cmd.second_idx = FW'(right_r);
        if (sts.out_free) begin
          evt_nxt   = evt_r + EW'(1);
          state_nxt = ST_REV_WA;
        end
      end
      ST_REV_WA: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = left_r;
        cmd.wr_sel  = nptr_pkg::WR_B;
        state_nxt   = ST_REV_WB;
      end
      ST_REV_WB: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = right_r;
        cmd.wr_sel  = nptr_pkg::WR_A;
        left_nxt    = left_r + IW'(1);
        right_nxt   = right_r - IW'(1);
        state_nxt   = ST_REV;
      end
      ST_ELEM_RD: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_addr_a = scan_idx;
        state_nxt     = ST_ELEM_EMIT;
      end
      ST_ELEM_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.kind      = nptr_pkg::KIND_ELEMENT;
        cmd.first_idx = FW'(scan_idx);
        cmd.val_sel   = 1'b1;
        if (sts.out_free) begin
          if (scan_idx == last_idx) begin
            state_nxt = ST_DONE;
          end else begin
            scan_nxt  = scan_r + CW'(1);
            state_nxt = ST_ELEM_RD;
          end
        end
      end
      ST_DONE: begin
        cmd.emit      = 1'b1;
        cmd.kind      = nptr_pkg::KIND_DONE;
        cmd.total     = evt_r + EW'(1);
        cmd.wrapped   = wrap_r;
        cmd.final_rec = 1'b1;
        if (sts.out_free) begin
          fill_nxt  = '0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      n_r     <= '0;
      scan_r  <= '0;
      pivot_r <= '0;
      left_r  <= '0;
      right_r <= '0;
      evt_r   <= '0;
      wrap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      n_r     <= n_nxt;
      scan_r  <= scan_nxt;
      pivot_r <= pivot_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      evt_r   <= evt_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

endmodule

/* rtl/nptr_checker.sv */
// Port-level checker for next_permutation_trace, attached with bind.
// Uses nptr_pkg for record kinds and widths.
module nptr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [nptr_pkg::KIND_W-1:0]       out_record_kind,
  input logic [nptr_pkg::EVT_W-1:0]        out_event_total,
  input logic                              out_wrapped,
  input logic                              out_final_record
);

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_record_kind)
      && $stable(out_event_total) && $stable(out_final_record))
    else $error("stalled output word changed");

  a_final_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_record |-> out_record_kind == nptr_pkg::KIND_DONE)
    else $error("final word is not a done record");

  a_trace_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != nptr_pkg::KIND_DONE |->
      out_event_total == '0 && !out_wrapped && !out_final_record)
    else $error("done-only fields set on a trace or element word");

  // A pending trace or element word means the walk is still running
  a_no_load_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind != nptr_pkg::KIND_DONE |-> !in_ready)
    else $error("input accepted while a walk is in progress");

endmodule

bind next_permutation_trace nptr_checker u_nptr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_record_kind  (out_chan.record_kind),
  .out_event_total  (out_chan.event_total),
  .out_wrapped      (out_chan.wrapped),
  .out_final_record (out_chan.final_record)
);
